// ===== src/isic_pkg.sv =====
package isic_pkg;

   // Fixed field widths of the request and response words.
   localparam int OPCODE_WIDTH = 2;
   localparam int BOUND_WIDTH  = 32;
   localparam int IDX_WIDTH    = 4;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_WIDTH  = 5;
   localparam int TOTAL_WIDTH  = 33;

   localparam int CAPACITY_DEFAULT    = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam logic [OPCODE_WIDTH-1:0] OP_ADD   = 2'd0;
   localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR = 2'd1;
   localparam logic [OPCODE_WIDTH-1:0] OP_READ  = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd2;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic insert;
      logic merge;
      logic absorb;
   } isic_cmd_type;

endpackage

// ===== src/interval_set_insert_coalesce_core.sv =====
// Channel   Ports                                        Handshake
// request   req_opcode req_bound_a req_bound_b           taken when start is high
//           req_entry_index                              and busy is low
// response  rsp_status rsp_interval_count rsp_lowest     rsp_valid strobe, one cycle,
//           rsp_highest rsp_covered_total                no backpressure
//           rsp_entry_low rsp_entry_high
//
// An accepted word passes through evaluation, a merge phase when an add touches a stored
// interval (one absorbed interval per step), and a wait for the registered reduction tree that
// forms the total, the read entry and the last high bound; the strobe follows. Busy stays
// high until the strobe cycle, in which a new word may already be taken. Synchronous reset
// empties the table; stored bounds are not cleared. The receiver cannot stall the response.
module interval_set_insert_coalesce_core #(
   parameter int CAPACITY    = isic_pkg::CAPACITY_DEFAULT,
   parameter int VALUE_WIDTH = isic_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic        [isic_pkg::OPCODE_WIDTH-1:0]   req_opcode,
   input  logic signed [isic_pkg::BOUND_WIDTH-1:0]    req_bound_a,
   input  logic signed [isic_pkg::BOUND_WIDTH-1:0]    req_bound_b,
   input  logic        [isic_pkg::IDX_WIDTH-1:0]      req_entry_index,
   output logic                                       rsp_valid,
   output logic        [isic_pkg::STATUS_WIDTH-1:0]   rsp_status,
   output logic        [isic_pkg::COUNT_WIDTH-1:0]    rsp_interval_count,
   output logic signed [isic_pkg::BOUND_WIDTH-1:0]    rsp_lowest,
   output logic signed [isic_pkg::BOUND_WIDTH-1:0]    rsp_highest,
   output logic        [isic_pkg::TOTAL_WIDTH-1:0]    rsp_covered_total,
   output logic signed [isic_pkg::BOUND_WIDTH-1:0]    rsp_entry_low,
   output logic signed [isic_pkg::BOUND_WIDTH-1:0]    rsp_entry_high
);
   import isic_pkg::*;

   localparam int VW     = VALUE_WIDTH;
   localparam int CW     = $clog2(CAPACITY + 1);
   localparam int LEVELS = $clog2(CAPACITY);
   localparam int WCW    = $clog2(LEVELS + 1);
   localparam int IW     = (CW > IDX_WIDTH) ? CW : IDX_WIDTH;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EVAL  = 2'd1;
   localparam logic [1:0] S_MERGE = 2'd2;
   localparam logic [1:0] S_SUM   = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [OPCODE_WIDTH-1:0]     op_ff, op_in;
   logic signed [VW-1:0]        lo_ff, lo_in, hi_ff, hi_in;
   logic [IDX_WIDTH-1:0]        idx_ff, idx_in;
   logic [STATUS_WIDTH-1:0]     status_ff, status_in;
   logic [WCW-1:0]              wait_ff, wait_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0]     rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0]      rsp_count_ff, rsp_count_in;
   logic signed [BOUND_WIDTH-1:0] rsp_lowest_ff, rsp_lowest_in;
   logic signed [BOUND_WIDTH-1:0] rsp_highest_ff, rsp_highest_in;
   logic [TOTAL_WIDTH-1:0]      rsp_total_ff, rsp_total_in;
   logic signed [BOUND_WIDTH-1:0] rsp_elo_ff, rsp_elo_in;
   logic signed [BOUND_WIDTH-1:0] rsp_ehi_ff, rsp_ehi_in;

   isic_cmd_type                cmd;
   logic signed [VW-1:0]        a_v, b_v;
   logic                        touch_any, absorb_any, full;

   logic [CAPACITY-1:0]         occ, occ_next, below, touch, hit, left_below;
   logic signed [VW-1:0]        cell_low [CAPACITY];
   logic signed [VW-1:0]        cell_high [CAPACITY];
   logic [VW:0]                 cell_len [CAPACITY];
   logic signed [VW-1:0]        left_low [CAPACITY];
   logic signed [VW-1:0]        left_high [CAPACITY];
   logic signed [VW-1:0]        right_low [CAPACITY];
   logic signed [VW-1:0]        right_high [CAPACITY];

   logic [VW:0]                 leaf_len [CAPACITY];
   logic [VW-1:0]               leaf_elo [CAPACITY];
   logic [VW-1:0]               leaf_ehi [CAPACITY];
   logic [VW-1:0]               leaf_lhi [CAPACITY];
   logic [VW:0]                 tree_total;
   logic signed [VW-1:0]        tree_elo, tree_ehi, tree_lhi;

   // Bounds are read as VW-bit two's complement values.
   assign a_v = VW'($unsigned(req_bound_a));
   assign b_v = VW'($unsigned(req_bound_b));

   for (genvar k = 0; k < CAPACITY; k++) begin : g_row
      assign occ[k] = CW'(k) < count_ff;

      if (k == 0) begin : g_head
         assign left_below[k] = 1'b1;
         assign left_low[k]   = '0;
         assign left_high[k]  = '0;
      end else begin : g_mid
         assign left_below[k] = below[k-1];
         assign left_low[k]   = cell_low[k-1];
         assign left_high[k]  = cell_high[k-1];
      end

      if (k == CAPACITY - 1) begin : g_tail
         assign occ_next[k]   = 1'b0;
         assign right_low[k]  = '0;
         assign right_high[k] = '0;
      end else begin : g_body
         assign occ_next[k]   = occ[k+1];
         assign right_low[k]  = cell_low[k+1];
         assign right_high[k] = cell_high[k+1];
      end

      isic_cell #(
         .VW(VW)
      ) u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .req_lo        (lo_ff),
         .req_hi        (hi_ff),
         .occupied      (occ[k]),
         .right_occupied(occ_next[k]),
         .left_below    (left_below[k]),
         .left_low      (left_low[k]),
         .left_high     (left_high[k]),
         .right_low     (right_low[k]),
         .right_high    (right_high[k]),
         .low           (cell_low[k]),
         .high          (cell_high[k]),
         .length        (cell_len[k]),
         .below         (below[k]),
         .touch         (touch[k]),
         .absorb_hit    (hit[k])
      );

      assign leaf_len[k] = occ[k] ? cell_len[k] : '0;
      assign leaf_elo[k] = (op_ff == OP_READ && occ[k] && IW'(k) == IW'(idx_ff)) ?
                           cell_low[k] : '0;
      assign leaf_ehi[k] = (op_ff == OP_READ && occ[k] && IW'(k) == IW'(idx_ff)) ?
                           cell_high[k] : '0;
      assign leaf_lhi[k] = (occ[k] && !occ_next[k]) ? cell_high[k] : '0;
   end

   isic_reduce_tree #(
      .N (CAPACITY),
      .VW(VW)
   ) u_tree (
      .clock   (clock),
      .leaf_len(leaf_len),
      .leaf_elo(leaf_elo),
      .leaf_ehi(leaf_ehi),
      .leaf_lhi(leaf_lhi),
      .total   (tree_total),
      .entry_lo(tree_elo),
      .entry_hi(tree_ehi),
      .last_hi (tree_lhi)
   );

   assign touch_any  = |touch;
   assign absorb_any = |hit;
   assign full       = (count_ff == CW'(CAPACITY));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      op_in          = op_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      idx_in         = idx_ff;
      status_in      = status_ff;
      wait_in        = wait_ff;
      cmd            = '0;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_lowest_in  = rsp_lowest_ff;
      rsp_highest_in = rsp_highest_ff;
      rsp_total_in   = rsp_total_ff;
      rsp_elo_in     = rsp_elo_ff;
      rsp_ehi_in     = rsp_ehi_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in     = req_opcode;
               lo_in     = (a_v <= b_v) ? a_v : b_v;
               hi_in     = (a_v <= b_v) ? b_v : a_v;
               idx_in    = req_entry_index;
               status_in = ST_OK;
               state_in  = S_EVAL;
            end
         end
         S_EVAL: begin
            wait_in  = WCW'(LEVELS);
            state_in = S_SUM;
            case (op_ff)
               OP_ADD: begin
                  if (touch_any) begin
                     cmd.merge = 1'b1;
                     state_in  = S_MERGE;
                  end else if (full) begin
                     status_in = ST_FULL;
                  end else begin
                     cmd.insert = 1'b1;
                     count_in   = count_ff + CW'(1);
                  end
               end
               OP_CLEAR: begin
                  count_in = '0;
               end
               OP_READ: begin
                  if (IW'(idx_ff) >= IW'(count_ff)) begin
                     status_in = ST_EMPTY;
                  end
               end
               default: begin
               end
            endcase
         end
         S_MERGE: begin
            // One following interval is absorbed per cycle until the anchor no longer reaches.
            if (absorb_any) begin
               cmd.absorb = 1'b1;
               count_in   = count_ff - CW'(1);
            end else begin
               state_in = S_SUM;
            end
         end
         S_SUM: begin
            if (wait_ff == '0) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_count_in   = COUNT_WIDTH'(count_ff);
               rsp_lowest_in  = (count_ff != '0) ? BOUND_WIDTH'(cell_low[0]) : '0;
               rsp_highest_in = BOUND_WIDTH'(tree_lhi);
               rsp_total_in   = TOTAL_WIDTH'(tree_total);
               rsp_elo_in     = BOUND_WIDTH'(tree_elo);
               rsp_ehi_in     = BOUND_WIDTH'(tree_ehi);
               state_in       = S_IDLE;
            end else begin
               wait_in = wait_ff - WCW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      idx_ff         <= idx_in;
      status_ff      <= status_in;
      wait_ff        <= wait_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_lowest_ff  <= rsp_lowest_in;
      rsp_highest_ff <= rsp_highest_in;
      rsp_total_ff   <= rsp_total_in;
      rsp_elo_ff     <= rsp_elo_in;
      rsp_ehi_ff     <= rsp_ehi_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_interval_count = rsp_count_ff;
   assign rsp_lowest         = rsp_lowest_ff;
   assign rsp_highest        = rsp_highest_ff;
   assign rsp_covered_total  = rsp_total_ff;
   assign rsp_entry_low      = rsp_elo_ff;
   assign rsp_entry_high     = rsp_ehi_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("interval count exceeds capacity");

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_EVAL))
      else $error("accepted word did not enter evaluation");

   a_absorb_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MERGE && absorb_any) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("absorb step did not drop one interval");

   a_strobe: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM && wait_ff == '0) |=> (rsp_valid && !busy))
      else $error("response strobe missing after reduction");

endmodule

// ===== src/isic_cell.sv =====
module isic_cell #(
   parameter int VW = isic_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  isic_pkg::isic_cmd_type cmd,
   input  logic signed [VW-1:0]   req_lo,
   input  logic signed [VW-1:0]   req_hi,
   input  logic                   occupied,
   input  logic                   right_occupied,
   input  logic                   left_below,
   input  logic signed [VW-1:0]   left_low,
   input  logic signed [VW-1:0]   left_high,
   input  logic signed [VW-1:0]   right_low,
   input  logic signed [VW-1:0]   right_high,
   output logic signed [VW-1:0]   low,
   output logic signed [VW-1:0]   high,
   output logic [VW:0]            length,
   output logic                   below,
   output logic                   touch,
   output logic                   absorb_hit
);
   import isic_pkg::*;

   localparam logic signed [VW:0] ONE = (VW+1)'(1);

   logic signed [VW-1:0] low_ff, low_in, high_ff, high_in;
   logic                 anchor_ff, anchor_in, after_ff, after_in;
   logic signed [VW:0]   low_x, high_x, lo_x, hi_x, right_low_x;
   logic                 above, anchor_now;

   assign low_x       = {low_ff[VW-1], low_ff};
   assign high_x      = {high_ff[VW-1], high_ff};
   assign lo_x        = {req_lo[VW-1], req_lo};
   assign hi_x        = {req_hi[VW-1], req_hi};
   assign right_low_x = {right_low[VW-1], right_low};

   // Widened by one bit so that the adjacency test cannot overflow.
   assign below      = occupied && ((high_x + ONE) < lo_x);
   assign above      = occupied && ((hi_x + ONE) < low_x);
   assign touch      = occupied && !below && !above;
   assign anchor_now = !below && left_below;
   assign absorb_hit = anchor_ff && right_occupied && !((high_x + ONE) < right_low_x);
   assign length     = high_x - low_x + ONE;

   assign low  = low_ff;
   assign high = high_ff;

   always_comb begin
      low_in    = low_ff;
      high_in   = high_ff;
      anchor_in = anchor_ff;
      after_in  = after_ff;
      if (cmd.insert) begin
         if (!below) begin
            if (anchor_now) begin
               low_in  = req_lo;
               high_in = req_hi;
            end else begin
               low_in  = left_low;
               high_in = left_high;
            end
         end
      end else if (cmd.merge) begin
         if (anchor_now) begin
            low_in  = (req_lo < low_ff) ? req_lo : low_ff;
            high_in = (req_hi > high_ff) ? req_hi : high_ff;
         end
         anchor_in = anchor_now;
         after_in  = !below && !anchor_now;
      end else if (cmd.absorb) begin
         // The anchor swallows its right neighbor; everything after it moves left.
         if (anchor_ff) begin
            high_in = (right_high > high_ff) ? right_high : high_ff;
         end else if (after_ff) begin
            low_in  = right_low;
            high_in = right_high;
         end
      end
   end

   always_ff @(posedge clock) begin
      low_ff    <= low_in;
      high_ff   <= high_in;
      anchor_ff <= anchor_in;
      after_ff  <= after_in;
   end

endmodule

// ===== src/isic_reduce_tree.sv =====
module isic_reduce_tree #(
   parameter int N  = isic_pkg::CAPACITY_DEFAULT,
   parameter int VW = isic_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic [VW:0]   leaf_len [N],
   input  logic [VW-1:0] leaf_elo [N],
   input  logic [VW-1:0] leaf_ehi [N],
   input  logic [VW-1:0] leaf_lhi [N],
   output logic [VW:0]   total,
   output logic [VW-1:0] entry_lo,
   output logic [VW-1:0] entry_hi,
   output logic [VW-1:0] last_hi
);
   import isic_pkg::*;

   localparam int LEVELS = $clog2(N);
   localparam int LEAVES = 1 << LEVELS;

   logic [VW:0]   pad_len [LEAVES];
   logic [VW-1:0] pad_elo [LEAVES];
   logic [VW-1:0] pad_ehi [LEAVES];
   logic [VW-1:0] pad_lhi [LEAVES];

   logic [VW:0]   sum_ff [1:LEAVES-1];
   logic [VW-1:0] elo_ff [1:LEAVES-1];
   logic [VW-1:0] ehi_ff [1:LEAVES-1];
   logic [VW-1:0] lhi_ff [1:LEAVES-1];

   for (genvar j = 0; j < LEAVES; j++) begin : g_pad
      if (j < N) begin : g_used
         assign pad_len[j] = leaf_len[j];
         assign pad_elo[j] = leaf_elo[j];
         assign pad_ehi[j] = leaf_ehi[j];
         assign pad_lhi[j] = leaf_lhi[j];
      end else begin : g_zero
         assign pad_len[j] = '0;
         assign pad_elo[j] = '0;
         assign pad_ehi[j] = '0;
         assign pad_lhi[j] = '0;
      end
   end

   // Node i sums or merges nodes 2i and 2i+1; every leaf-to-root path has LEVELS registers.
   // The intervals are disjoint, so no partial sum exceeds 2**VW.
   for (genvar i = 1; i < LEAVES; i++) begin : g_node
      if (2 * i >= LEAVES) begin : g_bottom
         always_ff @(posedge clock) begin
            sum_ff[i] <= pad_len[2*i-LEAVES] + pad_len[2*i+1-LEAVES];
            elo_ff[i] <= pad_elo[2*i-LEAVES] | pad_elo[2*i+1-LEAVES];
            ehi_ff[i] <= pad_ehi[2*i-LEAVES] | pad_ehi[2*i+1-LEAVES];
            lhi_ff[i] <= pad_lhi[2*i-LEAVES] | pad_lhi[2*i+1-LEAVES];
         end
      end else begin : g_inner
         always_ff @(posedge clock) begin
            sum_ff[i] <= sum_ff[2*i] + sum_ff[2*i+1];
            elo_ff[i] <= elo_ff[2*i] | elo_ff[2*i+1];
            ehi_ff[i] <= ehi_ff[2*i] | ehi_ff[2*i+1];
            lhi_ff[i] <= lhi_ff[2*i] | lhi_ff[2*i+1];
         end
      end
   end

   assign total    = sum_ff[1];
   assign entry_lo = elo_ff[1];
   assign entry_hi = ehi_ff[1];
   assign last_hi  = lhi_ff[1];

endmodule

// ===== bench/interval_set_insert_coalesce_core_test.sv =====
module interval_set_insert_coalesce_core_test;
   import isic_pkg::*;

   localparam int CAPACITY      = CAPACITY_DEFAULT;
   localparam int PLAN_ROWS     = 26;
   localparam int RANDOM_WORDS  = 1925;
   localparam int QUIET_TAIL    = 300;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 40;

   localparam logic [OPCODE_WIDTH-1:0]       OP_SPARE   = 2'd3;
   localparam logic signed [BOUND_WIDTH-1:0] BOUND_MIN  = 32'sh8000_0000;
   localparam logic signed [BOUND_WIDTH-1:0] BOUND_MAX  = 32'sh7fff_ffff;
   localparam logic [TOTAL_WIDTH-1:0]        FULL_RANGE = 33'h1_0000_0000;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]       status;
      logic [COUNT_WIDTH-1:0]        count;
      logic signed [BOUND_WIDTH-1:0] lowest;
      logic signed [BOUND_WIDTH-1:0] highest;
      logic [TOTAL_WIDTH-1:0]        total;
      logic signed [BOUND_WIDTH-1:0] entry_low;
      logic signed [BOUND_WIDTH-1:0] entry_high;
   } summary_type;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0]       opcode;
      logic signed [BOUND_WIDTH-1:0] bound_a;
      logic signed [BOUND_WIDTH-1:0] bound_b;
      logic [IDX_WIDTH-1:0]          index;
      logic                          pinned;
      summary_type                   want;
   } plan_row_type;

   localparam summary_type NO_WANT = '0;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic [OPCODE_WIDTH-1:0]       req_opcode;
   logic signed [BOUND_WIDTH-1:0] req_bound_a;
   logic signed [BOUND_WIDTH-1:0] req_bound_b;
   logic [IDX_WIDTH-1:0]          req_entry_index;
   logic                          rsp_valid;
   logic [STATUS_WIDTH-1:0]       rsp_status;
   logic [COUNT_WIDTH-1:0]        rsp_interval_count;
   logic signed [BOUND_WIDTH-1:0] rsp_lowest;
   logic signed [BOUND_WIDTH-1:0] rsp_highest;
   logic [TOTAL_WIDTH-1:0]        rsp_covered_total;
   logic signed [BOUND_WIDTH-1:0] rsp_entry_low;
   logic signed [BOUND_WIDTH-1:0] rsp_entry_high;

   // A directed row with a typed-in expectation travels alongside its word.
   logic        pin_on;
   summary_type pin_want;

   // Private copy of the interval table.
   longint span_lo [CAPACITY];
   longint span_hi [CAPACITY];
   int     span_count;

   summary_type  open_summaries [$];
   plan_row_type plan [PLAN_ROWS];

   int cycles;
   int words_sent;
   int words_taken;
   int summaries_seen;
   int mismatches;
   int full_refusals;
   int empty_reads;
   int absorbing_merges;

   interval_set_insert_coalesce_core dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_bound_a        (req_bound_a),
      .req_bound_b        (req_bound_b),
      .req_entry_index    (req_entry_index),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_interval_count (rsp_interval_count),
      .rsp_lowest         (rsp_lowest),
      .rsp_highest        (rsp_highest),
      .rsp_covered_total  (rsp_covered_total),
      .rsp_entry_low      (rsp_entry_low),
      .rsp_entry_high     (rsp_entry_high)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Merges [lo, hi] into the table, inserting it when it touches nothing.
   function automatic logic [STATUS_WIDTH-1:0] fold_in_span(longint lo, longint hi);
      int pos;
      int stop;
      int gone;
      int j;
      pos = 0;
      while (pos < span_count && span_hi[pos] < lo - 1) pos++;
      if (pos == span_count || hi < span_lo[pos] - 1) begin
         if (span_count >= CAPACITY) return ST_FULL;
         for (j = span_count; j > pos; j--) begin
            span_lo[j] = span_lo[j-1];
            span_hi[j] = span_hi[j-1];
         end
         span_lo[pos] = lo;
         span_hi[pos] = hi;
         span_count++;
         return ST_OK;
      end
      if (lo < span_lo[pos]) span_lo[pos] = lo;
      if (hi > span_hi[pos]) span_hi[pos] = hi;
      // Absorbing stops at the last entry; it never wraps around to the head.
      stop = pos + 1;
      while (stop < span_count && span_hi[pos] >= span_lo[stop] - 1) begin
         if (span_hi[stop] > span_hi[pos]) span_hi[pos] = span_hi[stop];
         stop++;
      end
      gone = stop - pos - 1;
      if (gone > 0) begin
         for (j = stop; j < span_count; j++) begin
            span_lo[j - gone] = span_lo[j];
            span_hi[j - gone] = span_hi[j];
         end
         span_count -= gone;
         absorbing_merges++;
      end
      return ST_OK;
   endfunction

   function automatic summary_type table_after(logic [OPCODE_WIDTH-1:0] opcode,
                                               logic signed [BOUND_WIDTH-1:0] a,
                                               logic signed [BOUND_WIDTH-1:0] b,
                                               logic [IDX_WIDTH-1:0] index);
      summary_type s;
      longint      sum;
      int          k;
      s = NO_WANT;
      sum = 0;
      case (opcode)
         OP_ADD: s.status = (a <= b) ? fold_in_span(a, b) : fold_in_span(b, a);
         OP_CLEAR: span_count = 0;
         OP_READ: begin
            if (int'(index) < span_count) begin
               s.entry_low  = span_lo[index][BOUND_WIDTH-1:0];
               s.entry_high = span_hi[index][BOUND_WIDTH-1:0];
            end else begin
               s.status = ST_EMPTY;
            end
         end
         default: ;
      endcase
      if (span_count > 0) begin
         s.lowest  = span_lo[0][BOUND_WIDTH-1:0];
         s.highest = span_hi[span_count-1][BOUND_WIDTH-1:0];
      end
      for (k = 0; k < span_count; k++) sum += span_hi[k] - span_lo[k] + 1;
      s.count = span_count[COUNT_WIDTH-1:0];
      s.total = sum[TOTAL_WIDTH-1:0];
      return s;
   endfunction

   task automatic flag(input string field, input longint want, input longint got);
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
   endtask

   // Checks each strobed word against the oldest expectation, then records the
   // expectation for a word taken at this edge.
   always @(posedge clock) begin
      summary_type want;
      summary_type next;
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else if (!reset) begin
         if (rsp_valid === 1'b1) begin
            summaries_seen++;
            if (open_summaries.size() == 0) begin
               $error("response word arrived with no request outstanding");
               mismatches++;
            end else begin
               want = open_summaries.pop_front();
               if (rsp_status !== want.status)
                  flag("status", want.status, rsp_status);
               if (rsp_interval_count !== want.count)
                  flag("interval_count", want.count, rsp_interval_count);
               if (rsp_lowest !== want.lowest)
                  flag("lowest", want.lowest, rsp_lowest);
               if (rsp_highest !== want.highest)
                  flag("highest", want.highest, rsp_highest);
               if (rsp_covered_total !== want.total)
                  flag("covered_total", want.total, rsp_covered_total);
               if (rsp_entry_low !== want.entry_low)
                  flag("entry_low", want.entry_low, rsp_entry_low);
               if (rsp_entry_high !== want.entry_high)
                  flag("entry_high", want.entry_high, rsp_entry_high);
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            words_taken++;
            next = table_after(req_opcode, req_bound_a, req_bound_b, req_entry_index);
            if (pin_on) next = pin_want;
            if (next.status == ST_FULL) full_refusals++;
            if (next.status == ST_EMPTY) empty_reads++;
            open_summaries.push_back(next);
         end
      end
   end

   // Drives one word and returns at the edge that takes it.
   task automatic issue(input plan_row_type row, input bit idle);
      if (idle && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_opcode      <= row.opcode;
      req_bound_a     <= row.bound_a;
      req_bound_b     <= row.bound_b;
      req_entry_index <= row.index;
      pin_on          <= row.pinned;
      pin_want        <= row.want;
      start           <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      words_sent++;
   endtask

   task automatic wait_all;
      start <= 1'b0;
      while (summaries_seen < words_sent) @(posedge clock);
   endtask

   initial begin
      int                            n;
      int                            pick;
      bit                            idle;
      logic [OPCODE_WIDTH-1:0]       op;
      logic signed [BOUND_WIDTH-1:0] a;
      logic signed [BOUND_WIDTH-1:0] b;
      logic signed [BOUND_WIDTH-1:0] window;
      logic [IDX_WIDTH-1:0]          idx;

      reset = 1'b1;
      start = 1'b0;
      req_opcode = OP_ADD;
      req_bound_a = '0;
      req_bound_b = '0;
      req_entry_index = '0;
      pin_on = 1'b0;
      pin_want = NO_WANT;
      span_count = 0;
      cycles = 0;
      words_sent = 0;
      words_taken = 0;
      summaries_seen = 0;
      mismatches = 0;
      full_refusals = 0;
      empty_reads = 0;
      absorbing_merges = 0;
      window = 32'sd0;

      plan[0]  = {OP_READ, 32'sd0, 32'sd0, 4'd0, 1'b1,
                  ST_EMPTY, 5'd0, 32'sd0, 32'sd0, 33'd0, 32'sd0, 32'sd0};
      plan[1]  = {OP_SPARE, BOUND_MAX, BOUND_MIN, 4'd15, 1'b1,
                  ST_OK, 5'd0, 32'sd0, 32'sd0, 33'd0, 32'sd0, 32'sd0};
      plan[2]  = {OP_ADD, BOUND_MAX, BOUND_MIN, 4'd0, 1'b1,
                  ST_OK, 5'd1, BOUND_MIN, BOUND_MAX, FULL_RANGE, 32'sd0, 32'sd0};
      plan[3]  = {OP_READ, 32'sd0, 32'sd0, 4'd0, 1'b1,
                  ST_OK, 5'd1, BOUND_MIN, BOUND_MAX, FULL_RANGE, BOUND_MIN, BOUND_MAX};
      plan[4]  = {OP_READ, 32'sd0, 32'sd0, 4'd15, 1'b1,
                  ST_EMPTY, 5'd1, BOUND_MIN, BOUND_MAX, FULL_RANGE, 32'sd0, 32'sd0};
      plan[5]  = {OP_ADD, 32'sd5, 32'sd7, 4'd0, 1'b1,
                  ST_OK, 5'd1, BOUND_MIN, BOUND_MAX, FULL_RANGE, 32'sd0, 32'sd0};
      plan[6]  = {OP_CLEAR, 32'sd0, 32'sd0, 4'd0, 1'b1,
                  ST_OK, 5'd0, 32'sd0, 32'sd0, 33'd0, 32'sd0, 32'sd0};
      // Single points two apart, inserted out of order until the table is full.
      plan[7]  = {OP_ADD, 32'sd16, 32'sd16, 4'd0, 1'b0, NO_WANT};
      plan[8]  = {OP_ADD, 32'sd0, 32'sd0, 4'd0, 1'b0, NO_WANT};
      plan[9]  = {OP_ADD, 32'sd30, 32'sd30, 4'd0, 1'b0, NO_WANT};
      plan[10] = {OP_ADD, 32'sd8, 32'sd8, 4'd0, 1'b0, NO_WANT};
      plan[11] = {OP_ADD, 32'sd24, 32'sd24, 4'd0, 1'b0, NO_WANT};
      plan[12] = {OP_ADD, 32'sd4, 32'sd4, 4'd0, 1'b0, NO_WANT};
      plan[13] = {OP_ADD, 32'sd12, 32'sd12, 4'd0, 1'b0, NO_WANT};
      plan[14] = {OP_ADD, 32'sd20, 32'sd20, 4'd0, 1'b0, NO_WANT};
      plan[15] = {OP_ADD, 32'sd28, 32'sd28, 4'd0, 1'b0, NO_WANT};
      plan[16] = {OP_ADD, 32'sd2, 32'sd2, 4'd0, 1'b0, NO_WANT};
      plan[17] = {OP_ADD, 32'sd6, 32'sd6, 4'd0, 1'b0, NO_WANT};
      plan[18] = {OP_ADD, 32'sd10, 32'sd10, 4'd0, 1'b0, NO_WANT};
      plan[19] = {OP_ADD, 32'sd14, 32'sd14, 4'd0, 1'b0, NO_WANT};
      plan[20] = {OP_ADD, 32'sd18, 32'sd18, 4'd0, 1'b0, NO_WANT};
      plan[21] = {OP_ADD, 32'sd22, 32'sd22, 4'd0, 1'b0, NO_WANT};
      plan[22] = {OP_ADD, 32'sd26, 32'sd26, 4'd0, 1'b0, NO_WANT};
      plan[23] = {OP_ADD, 32'sd100, 32'sd100, 4'd0, 1'b1,
                  ST_FULL, 5'd16, 32'sd0, 32'sd30, 33'd16, 32'sd0, 32'sd0};
      // Reversed bounds that reach every stored point and collapse the table.
      plan[24] = {OP_ADD, 32'sd29, 32'sd1, 4'd0, 1'b0, NO_WANT};
      plan[25] = {OP_READ, 32'sd0, 32'sd0, 4'd15, 1'b0, NO_WANT};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (n = 0; n < PLAN_ROWS; n++) issue(plan[n], 1'b1);
      wait_all();

      for (n = 0; n < RANDOM_WORDS; n++) begin
         idle = (n < RANDOM_WORDS - QUIET_TAIL) && ((n / 150) % 2 == 0);
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            op = OP_CLEAR;
            // Each fresh table lives in its own neighborhood, sometimes at an end.
            case ($urandom_range(0, 3))
               0: window = BOUND_MIN;
               1: window = BOUND_MAX - 32'sd100;
               2: window = $urandom;
               default: window = -32'sd50;
            endcase
            if ($urandom_range(0, 3) == 0) wait_all();
         end else if (pick < 4) begin
            op = OP_SPARE;
         end else if (pick < 30) begin
            op = OP_READ;
         end else begin
            op = OP_ADD;
         end
         case ($urandom_range(0, 15))
            0: a = $urandom;
            1: a = BOUND_MIN + $urandom_range(0, 40);
            2: a = BOUND_MAX - $urandom_range(0, 40);
            default: a = window + $urandom_range(0, 100);
         endcase
         case ($urandom_range(0, 15))
            0: b = $urandom;
            1, 2, 3: b = a - $urandom_range(0, 6);
            default: b = a + $urandom_range(0, 5);
         endcase
         idx = $urandom_range(0, 15);
         issue({op, a, b, idx, 1'b0, NO_WANT}, idle);
      end

      wait_all();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (open_summaries.size() != 0) begin
         $error("%0d response words never arrived", open_summaries.size());
         mismatches++;
      end

      $display("Ran %0d words (%0d from the directed table): %0d adds refused on a full table,",
               words_taken, PLAN_ROWS, full_refusals);
      $display("%0d reads past the held entries, %0d merges that absorbed neighbors.",
               empty_reads, absorbing_merges);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
